>>> sv/fixed_point_matrix_multiply_assert.svh
// Assertion macros for the matrix multiply RTL.
`ifndef FIXED_POINT_MATRIX_MULTIPLY_ASSERT_SVH
`define FIXED_POINT_MATRIX_MULTIPLY_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, clocked on clk, held off during reset
`define FPMM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpmm assertion failed");

// next-cycle implication
`define FPMM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpmm assertion failed");

`else

`define FPMM_ASSERT_IMP(lbl, ante, cons)
`define FPMM_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> sv/fpmm_pkg.sv
// Types, constants and helper functions for the fixed-point matrix multiply.
`default_nettype none

package fpmm_pkg;

    localparam int MAX_DIM   = 8;
    localparam int FRAC_BITS = 16;

    localparam int DIM_W     = 4;
    localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = ADDR_W + 1;
    localparam int ELEM_W    = 32;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = PROD_W - FRAC_BITS + IDX_W;
    localparam int CFG_IDX_W = 2;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_WAIT,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

    typedef struct packed {
        logic                     done;
        logic signed [ELEM_W-1:0] value;
        logic                     sat;
    } mac_res_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
            r = DIM_W'(1);
        else if (d > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/fpmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fpmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
    output      logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> sv/fpmm_mac.sv
// Shared multiply-accumulate unit: registered product, shift, wide sum, saturation.
`default_nettype none

module fpmm_mac (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire fpmm_pkg::mac_ctl_t                 ctl,
    input  wire logic signed [fpmm_pkg::ELEM_W-1:0] a,
    input  wire logic signed [fpmm_pkg::ELEM_W-1:0] b,
    output      fpmm_pkg::mac_res_t                 res
);
    import fpmm_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    mac_ctl_t                 ctl_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     done_reg;
    logic                     done_next;
    logic signed [PROD_W-1:0] shifted;
    logic signed [ACC_W-1:0]  term;
    logic                     over_hi;
    logic                     over_lo;

    always_comb
    begin
        prod_next = PROD_W'(a) * PROD_W'(b);
        shifted   = prod_reg >>> FRAC_BITS;
        term      = ACC_W'(shifted);
        acc_next  = acc_reg;
        if (ctl_reg.valid)
        begin
            acc_next = (ctl_reg.first ? '0 : acc_reg) + term;
        end
        done_next = ctl_reg.valid && ctl_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_reg  <= ctl;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // clip the sum to the signed 32-bit range
    always_comb
    begin
        over_hi   = !acc_reg[ACC_W-1] && (|acc_reg[ACC_W-2:ELEM_W-1]);
        over_lo   = acc_reg[ACC_W-1] && !(&acc_reg[ACC_W-2:ELEM_W-1]);
        res.done  = done_reg;
        res.sat   = over_hi || over_lo;
        res.value = acc_reg[ELEM_W-1:0];
        if (over_hi)
            res.value = {1'b0, {(ELEM_W-1){1'b1}}};
        else if (over_lo)
            res.value = {1'b1, {(ELEM_W-1){1'b0}}};
    end

endmodule

`default_nettype wire

>>> sv/fixed_point_matrix_multiply.sv
// Fixed-point matrix multiply top level: load sequencer, element stores, MAC control.
// Loading: one element per cycle, s_tready high while no product is being computed.
// Compute: each product element runs on the one shared MAC
//   (inner_dim read/issue steps, then RAM read, multiply and accumulate, then output).
// Computing starts once the last element of B has been accepted.
// Reset (rst_n, async, active low): dimensions go to 1, loading restarts at A;
//   the element stores are not cleared.
`default_nettype none

module fixed_point_matrix_multiply (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output      logic                                 s_tready,
    input  wire logic [fpmm_pkg::IN_W-1:0]            s_tdata,   // [31:0] elem_value
    output      logic                                 m_tvalid,
    input  wire logic                                 m_tready,
    output      logic [fpmm_pkg::OUT_W-1:0]           m_tdata,   // [31:0] prod_value,
                                                                 // [34:32] prod_row,
                                                                 // [37:35] prod_col
    output      logic                                 m_tlast,   // last_elem
    output      logic                                 m_tuser,   // saturated
    input  wire logic                                 cfg_valid,
    output      logic                                 cfg_ready,
    input  wire logic [fpmm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [fpmm_pkg::DIM_W-1:0]           cfg_data
);
    import fpmm_pkg::*;

`include "fixed_point_matrix_multiply_assert.svh"

    state_t                   state_reg;
    state_t                   state_next;
    logic [DIM_W-1:0]         rows_reg;
    logic [DIM_W-1:0]         rows_next;
    logic [DIM_W-1:0]         inner_reg;
    logic [DIM_W-1:0]         inner_next;
    logic [DIM_W-1:0]         cols_reg;
    logic [DIM_W-1:0]         cols_next;
    logic [CNT_W-1:0]         load_count_reg;
    logic [CNT_W-1:0]         load_count_next;
    logic                     loading_second_reg;
    logic                     loading_second_next;
    logic [IDX_W-1:0]         i_reg;
    logic [IDX_W-1:0]         i_next;
    logic [IDX_W-1:0]         j_reg;
    logic [IDX_W-1:0]         j_next;
    logic [IDX_W-1:0]         k_reg;
    logic [IDX_W-1:0]         k_next;
    logic [ADDR_W-1:0]        a_base_reg;
    logic [ADDR_W-1:0]        a_base_next;
    logic [ADDR_W-1:0]        b_addr_reg;
    logic [ADDR_W-1:0]        b_addr_next;
    mac_ctl_t                 issue_reg;
    mac_ctl_t                 issue_next;
    logic signed [ELEM_W-1:0] out_value_reg;
    logic                     out_sat_reg;

    logic [DIM_W-1:0]         ra;
    logic [DIM_W-1:0]         kd;
    logic [DIM_W-1:0]         cb;
    logic [2*DIM_W-1:0]       a_size;
    logic [2*DIM_W-1:0]       b_size;
    logic [CNT_W-1:0]         count_inc;
    logic                     in_fire;
    logic                     out_fire;
    logic                     cfg_fire;
    logic                     cfg_hit;
    logic                     load_a_done;
    logic                     load_b_done;
    logic                     k_last;
    logic                     i_last;
    logic                     j_last;
    logic                     issuing;
    logic                     wr_a;
    logic                     wr_b;
    logic [ADDR_W-1:0]        a_rd_addr;
    logic [ELEM_W-1:0]        a_rd_data;
    logic [ELEM_W-1:0]        b_rd_data;
    mac_res_t                 mac_res;

    always_comb
    begin
        ra          = clamp_dim(rows_reg);
        kd          = clamp_dim(inner_reg);
        cb          = clamp_dim(cols_reg);
        a_size      = (2*DIM_W)'(ra) * (2*DIM_W)'(kd);
        b_size      = (2*DIM_W)'(kd) * (2*DIM_W)'(cb);
        count_inc   = load_count_reg + CNT_W'(1);
        in_fire     = s_tvalid && s_tready;
        out_fire    = m_tvalid && m_tready;
        cfg_fire    = cfg_valid && cfg_ready;
        cfg_hit     = cfg_fire && (cfg_index == CFG_ROWS_A || cfg_index == CFG_INNER_DIM
                                   || cfg_index == CFG_COLS_B);
        load_a_done = !loading_second_reg && ((2*DIM_W)'(count_inc) >= a_size);
        load_b_done = loading_second_reg && ((2*DIM_W)'(count_inc) >= b_size);
        k_last      = ({1'b0, k_reg} == DIM_W'(kd - DIM_W'(1)));
        i_last      = ({1'b0, i_reg} == DIM_W'(ra - DIM_W'(1)));
        j_last      = ({1'b0, j_reg} == DIM_W'(cb - DIM_W'(1)));
        a_rd_addr   = a_base_reg + ADDR_W'(k_reg);
        wr_a        = in_fire && !loading_second_reg;
        wr_b        = in_fire && loading_second_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && load_b_done)
                    state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                if (k_last)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mac_res.done)
                    state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_fire)
                    state_next = (i_last && j_last) ? ST_LOAD : ST_ISSUE;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        cfg_ready = 1'b0;
        m_tvalid  = 1'b0;
        issuing   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                s_tready  = 1'b1;
                cfg_ready = 1'b1;
            end
            ST_ISSUE:
            begin
                issuing = 1'b1;
            end
            ST_WAIT:
            begin
            end
            ST_SEND:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rows_next           = rows_reg;
        inner_next          = inner_reg;
        cols_next           = cols_reg;
        load_count_next     = load_count_reg;
        loading_second_next = loading_second_reg;
        i_next              = i_reg;
        j_next              = j_reg;
        k_next              = k_reg;
        a_base_next         = a_base_reg;
        b_addr_next         = b_addr_reg;
        issue_next          = '0;

        if (cfg_hit)
        begin
            case (cfg_index)
                CFG_ROWS_A:    rows_next  = cfg_data;
                CFG_INNER_DIM: inner_next = cfg_data;
                CFG_COLS_B:    cols_next  = cfg_data;
                default:       rows_next  = rows_reg;
            endcase
            load_count_next     = '0;
            loading_second_next = 1'b0;
        end

        if (in_fire)
        begin
            if (load_a_done || load_b_done)
            begin
                load_count_next     = '0;
                loading_second_next = !loading_second_reg;
            end
            else
            begin
                load_count_next = count_inc;
            end
            if (load_b_done)
            begin
                i_next      = '0;
                j_next      = '0;
                k_next      = '0;
                a_base_next = '0;
                b_addr_next = '0;
            end
        end

        if (issuing)
        begin
            issue_next.valid = 1'b1;
            issue_next.first = (k_reg == '0);
            issue_next.last  = k_last;
            k_next           = k_last ? '0 : k_reg + IDX_W'(1);
            b_addr_next      = b_addr_reg + ADDR_W'(cb);
        end

        if (out_fire)
        begin
            if (j_last)
            begin
                j_next      = '0;
                b_addr_next = '0;
                if (i_last)
                begin
                    i_next      = '0;
                    a_base_next = '0;
                end
                else
                begin
                    i_next      = i_reg + IDX_W'(1);
                    a_base_next = a_base_reg + ADDR_W'(kd);
                end
            end
            else
            begin
                j_next      = j_reg + IDX_W'(1);
                b_addr_next = ADDR_W'(j_reg) + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_LOAD;
            rows_reg           <= DIM_W'(1);
            inner_reg          <= DIM_W'(1);
            cols_reg           <= DIM_W'(1);
            load_count_reg     <= '0;
            loading_second_reg <= 1'b0;
            i_reg              <= '0;
            j_reg              <= '0;
            k_reg              <= '0;
            a_base_reg         <= '0;
            b_addr_reg         <= '0;
            issue_reg          <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            rows_reg           <= rows_next;
            inner_reg          <= inner_next;
            cols_reg           <= cols_next;
            load_count_reg     <= load_count_next;
            loading_second_reg <= loading_second_next;
            i_reg              <= i_next;
            j_reg              <= j_next;
            k_reg              <= k_next;
            a_base_reg         <= a_base_next;
            b_addr_reg         <= b_addr_next;
            issue_reg          <= issue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WAIT && mac_res.done)
        begin
            out_value_reg <= mac_res.value;
            out_sat_reg   <= mac_res.sat;
        end
    end

    fpmm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_store_a (
        .clk     (clk),
        .wr_en   (wr_a),
        .wr_addr (load_count_reg[ADDR_W-1:0]),
        .wr_data (s_tdata[ELEM_W-1:0]),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    fpmm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_store_b (
        .clk     (clk),
        .wr_en   (wr_b),
        .wr_addr (load_count_reg[ADDR_W-1:0]),
        .wr_data (s_tdata[ELEM_W-1:0]),
        .rd_addr (b_addr_reg),
        .rd_data (b_rd_data)
    );

    fpmm_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (issue_reg),
        .a     (a_rd_data),
        .b     (b_rd_data),
        .res   (mac_res)
    );

    always_comb
    begin
        m_tdata = {(OUT_W - ELEM_W - 2*IDX_W)'(0), j_reg, i_reg, out_value_reg};
        m_tlast = i_last && j_last;
        m_tuser = out_sat_reg;
    end

    `FPMM_ASSERT_IMP(a_done_in_wait, mac_res.done, state_reg == ST_WAIT)
    `FPMM_ASSERT_IMP(a_load_bound, !loading_second_reg,
                     (2*DIM_W)'(load_count_reg) < a_size)
    `FPMM_ASSERT_IMP(a_k_bound, state_reg == ST_ISSUE, {1'b0, k_reg} < kd)
    `FPMM_ASSERT_NXT(a_issue_to_mac, issuing && k_last, issue_reg.valid && issue_reg.last)

endmodule

`default_nettype wire

>>> verif/fixed_point_matrix_multiply_tb.sv
// Self-checking testbench for fixed_point_matrix_multiply: streamed matrices, predicted products.
`timescale 1ns / 1ps

module fixed_point_matrix_multiply_tb;

    import fpmm_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES = 40;
    localparam int HOLD_CYCLES = 500;
    localparam int RANDOM_ITEMS_PER_PHASE = 8;
    localparam int MAX_REPORTS = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [31:0] ELEM_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] ELEM_MIN = 32'h8000_0000;
    localparam logic [31:0] ELEM_NEG_LSB = 32'hFFFF_FFFF;
    localparam logic [31:0] ELEM_ONE = 32'h0001_0000;

    typedef struct {
        logic signed [31:0] value;
        logic [2:0]         row;
        logic [2:0]         col;
        logic               last;
        logic               sat;
    } prod_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic m_tlast;
    logic m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0] cfg_data = '0;

    // predictor state
    logic [DIM_W-1:0]   rows_reg = 4'd1;
    logic [DIM_W-1:0]   inner_reg = 4'd1;
    logic [DIM_W-1:0]   cols_reg = 4'd1;
    logic signed [31:0] a_mem [DEPTH];
    logic signed [31:0] b_mem [DEPTH];
    int unsigned        fill_cnt = 0;
    bit                 on_b = 1'b0;

    logic [31:0] elem_q [$];
    prod_t       prod_q [$];
    int unsigned n_queued = 0;
    int unsigned n_accepted = 0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_off = 1'b0;

    fixed_point_matrix_multiply dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned dim_eff(input logic [DIM_W-1:0] d);
        if (d == '0)
            return 1;
        if (d > MAX_DIM)
            return MAX_DIM;
        return d;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        case (idx)
            CFG_ROWS_A:    rows_reg = val;
            CFG_INNER_DIM: inner_reg = val;
            CFG_COLS_B:    cols_reg = val;
            default:       return;
        endcase
        fill_cnt = 0;
        on_b = 1'b0;
    endfunction

    function automatic void multiply_out();
        int unsigned ra;
        int unsigned kd;
        int unsigned cb;
        longint      acc;
        longint      term;
        prod_t       p;
        ra = dim_eff(rows_reg);
        kd = dim_eff(inner_reg);
        cb = dim_eff(cols_reg);
        for (int i = 0; i < ra; i++)
        begin
            for (int j = 0; j < cb; j++)
            begin
                acc = 0;
                for (int k = 0; k < kd; k++)
                begin
                    term = longint'(a_mem[i * kd + k]) * longint'(b_mem[k * cb + j]);
                    acc += term >>> FRAC_BITS;
                end
                p.sat = 1'b1;
                if (acc > longint'(32'sh7FFF_FFFF))
                    acc = 32'sh7FFF_FFFF;
                else if (acc < longint'(32'sh8000_0000))
                    acc = -64'sd2147483648;
                else
                    p.sat = 1'b0;
                p.value = 32'(acc);
                p.row = 3'(i);
                p.col = 3'(j);
                p.last = (i == ra - 1) && (j == cb - 1);
                prod_q.push_back(p);
            end
        end
    endfunction

    function automatic void load_elem(input logic [31:0] elem);
        if (!on_b)
        begin
            a_mem[fill_cnt] = elem;
            fill_cnt++;
            if (fill_cnt >= dim_eff(rows_reg) * dim_eff(inner_reg))
            begin
                fill_cnt = 0;
                on_b = 1'b1;
            end
        end
        else
        begin
            b_mem[fill_cnt] = elem;
            fill_cnt++;
            if (fill_cnt >= dim_eff(inner_reg) * dim_eff(cols_reg))
            begin
                fill_cnt = 0;
                on_b = 1'b0;
                multiply_out();
            end
        end
    endfunction

    function automatic void flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                load_elem(s_tdata[31:0]);
                n_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (elem_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tdata  <= elem_q.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        prod_t exp_p;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (prod_q.size() == 0)
                    flag_error($sformatf("unexpected product: value %h row %0d col %0d",
                                         m_tdata[31:0], m_tdata[34:32], m_tdata[37:35]));
                else
                begin
                    exp_p = prod_q.pop_front();
                    if (m_tdata[31:0] !== exp_p.value || m_tdata[34:32] !== exp_p.row ||
                        m_tdata[37:35] !== exp_p.col || m_tlast !== exp_p.last ||
                        m_tuser !== exp_p.sat)
                        flag_error($sformatf({"product mismatch: expected value %h row %0d ",
                                              "col %0d last %b sat %b, got value %h row %0d ",
                                              "col %0d last %b sat %b"},
                                             exp_p.value, exp_p.row, exp_p.col, exp_p.last,
                                             exp_p.sat, m_tdata[31:0], m_tdata[34:32],
                                             m_tdata[37:35], m_tlast, m_tuser));
                end
            end
            m_tready <= hold_off ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_elem(input logic [31:0] elem);
        elem_q.push_back(elem);
        n_queued++;
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (n_accepted != n_queued || prod_q.size() != 0);
    endtask

    // a partial load leaves the block busy-free but give it time anyway
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] kd,
                            input logic [DIM_W-1:0] cb);
        settle();
        cfg_write(CFG_ROWS_A, ra);
        cfg_write(CFG_INNER_DIM, kd);
        cfg_write(CFG_COLS_B, cb);
    endtask

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(9))
            0, 1, 2, 3: return 32'(int'($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
            4:          return 32'(int'($urandom_range(32'h0200_0000)) - 32'sh0100_0000);
            5, 6:       return $urandom();
            7:
            begin
                case ($urandom_range(3))
                    0:       return ELEM_MAX;
                    1:       return ELEM_MIN;
                    2:       return ELEM_NEG_LSB;
                    default: return '0;
                endcase
            end
            default:    return $urandom_range(1) ? ELEM_ONE : -ELEM_ONE;
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        if ($urandom_range(5) == 0)
            return DIM_W'($urandom_range(15));
        return DIM_W'($urandom_range(3, 1));
    endfunction

    initial
    begin
        int unsigned send_pct [4] = '{0, 56, 0, 29};
        int unsigned recv_pct [4] = '{0, 0, 56, 29};
        int unsigned phase_items;
        int unsigned n;
        logic [DIM_W-1:0] ra;
        logic [DIM_W-1:0] kd;
        logic [DIM_W-1:0] cb;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sizes after reset are 1x1x1
        push_elem(ELEM_MAX);
        push_elem(ELEM_MAX);

        set_dims(4'd1, 4'd1, 4'd1);
        push_elem(ELEM_MIN);
        push_elem(ELEM_MIN);
        push_elem(ELEM_MIN);
        push_elem(ELEM_MAX);
        push_elem(ELEM_NEG_LSB);
        push_elem(ELEM_ONE);
        push_elem(32'h0001_8000);
        push_elem(32'hFFFE_0000);

        // write to an unused index keeps the partial load
        push_elem(32'h0003_0000);
        settle();
        cfg_write(CFG_UNUSED, 4'hF);
        push_elem(32'h0002_8000);

        // real register write drops the partial load
        push_elem(32'h7FFF_0000);
        settle();
        cfg_write(CFG_ROWS_A, 4'd1);
        push_elem(32'h0000_4000);
        push_elem(32'h0004_0000);

        // zero sizes act as one; in-range products that overflow when summed
        set_dims(4'd0, 4'd2, 4'd0);
        push_elem(32'h7FFF_0000);
        push_elem(32'h7FFF_0000);
        push_elem(ELEM_ONE);
        push_elem(ELEM_ONE);

        // oversize row count acts as eight
        set_dims(4'd15, 4'd1, 4'd1);
        repeat (9) push_elem(rand_elem());

        // output held off while several matrix pairs queue up at the input
        set_dims(4'd2, 4'd2, 4'd2);
        fork
            begin
                @(negedge clk);
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
            end
        join_none
        repeat (24) push_elem(rand_elem());

        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            send_idle_pct = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS_PER_PHASE)
            begin
                if ($urandom_range(2) != 0)
                begin
                    ra = pick_dim();
                    kd = pick_dim();
                    cb = pick_dim();
                    settle();
                    if ($urandom_range(5) == 0)
                        cfg_write(CFG_UNUSED, DIM_W'($urandom_range(15)));
                    cfg_write(CFG_ROWS_A, ra);
                    cfg_write(CFG_INNER_DIM, kd);
                    cfg_write(CFG_COLS_B, cb);
                end
                n = dim_eff(rows_reg) * dim_eff(inner_reg) +
                    dim_eff(inner_reg) * dim_eff(cols_reg);
                // occasionally a cut-off pair, dropped by the next register write
                if ($urandom_range(7) == 0)
                begin
                    n = $urandom_range(n - 1, 1);
                    repeat (n) push_elem(rand_elem());
                    settle();
                    cfg_write(CFG_COLS_B, cols_reg);
                end
                else
                    repeat (n) push_elem(rand_elem());
                phase_items += n;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (prod_q.size() != 0)
            $display("%0d expected products never arrived", prod_q.size());
        if (err_count == 0 && prod_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/fpmm_pkg.sv
sv/fpmm_ram.sv
sv/fpmm_mac.sv
sv/fixed_point_matrix_multiply.sv
verif/fixed_point_matrix_multiply_tb.sv
